// ===== sv/assert_macros.svh =====
// Assertion macros used by qte_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/qte_pkg.sv =====
package qte_pkg;

    typedef enum logic [1:0] {
        Q_W = 2'd0,
        Q_X = 2'd1,
        Q_Y = 2'd2,
        Q_Z = 2'd3
    } quat_sel_t;

    typedef enum logic [1:0] {
        ACC_LOAD = 2'd0,
        ACC_ADD  = 2'd1,
        ACC_SUB  = 2'd2
    } acc_mode_t;

    typedef enum logic {
        ACC_A = 1'b0,
        ACC_B = 1'b1
    } acc_dst_t;

    typedef enum logic {
        SRC_PITCH = 1'b0,
        SRC_EULER = 1'b1
    } atan_src_t;

    typedef struct packed {
        logic      load_in;
        quat_sel_t mul_a_sel;
        quat_sel_t mul_b_sel;
        logic      acc_en;
        acc_dst_t  acc_dst;
        acc_mode_t acc_mode;
        logic      s_load;
        logic      sq_load;
        logic      root_init;
        logic      root_step;
        logic      atan_init;
        atan_src_t atan_src;
        logic      atan_step;
        logic      pitch_store;
        logic      yaw_store;
        logic      roll_store;
        logic      roll_hold;
        logic      out_load;
    } qte_cmd_t;

    typedef struct packed {
        logic root_done;
        logic atan_done;
        logic pole_ok;
    } qte_status_t;

    localparam logic [13:0] MARGIN_RESET = 14'd410;

    function automatic logic [23:0] atan_q24(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qte_datapath.sv =====
module qte_datapath
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [13:0]        cfg_data,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  qte_cmd_t           cmd,
    output qte_status_t        status,
    output logic signed [15:0] roll,
    output logic signed [14:0] pitch,
    output logic signed [15:0] yaw,
    output logic               roll_held
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int CW = 36;
    localparam logic signed [CW-1:0] ONE_Q28 = 36'sd268435456;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [16:0] LIM_HALF = 17'sd12868;
    localparam logic signed [16:0] LIM_FULL = 17'sd25736;
    localparam logic [56:0] ONE_Q56 = 57'h100000000000000;

    logic [13:0]        margin_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [32:0] acc_a_reg, acc_b_reg;
    logic signed [29:0] s_reg;
    logic [56:0]        sq_reg;
    logic [56:0]        n_reg, bit_reg;
    logic [57:0]        r_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [27:0] z_reg;
    logic [IW-1:0]      it_reg;
    logic               zero_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg, roll_reg, last_roll_reg;
    logic               held_reg;
    logic signed [15:0] roll_out_reg, yaw_out_reg;
    logic signed [14:0] pitch_out_reg;
    logic               held_out_reg;

    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] prod;
    logic signed [32:0] prod_ext, acc_cur, acc_next;
    logic signed [33:0] s_dbl;
    logic signed [29:0] s_next;
    logic signed [59:0] sq_full;
    logic [57:0]        trial;
    logic signed [CW-1:0] xi, yi, xs, ys;
    logic signed [27:0] atan_ext, z_round;
    logic signed [16:0] angle, thr, pitch_ext;

    function automatic logic signed [15:0] pick(input quat_sel_t sel,
                                                input logic signed [15:0] w,
                                                input logic signed [15:0] x,
                                                input logic signed [15:0] y,
                                                input logic signed [15:0] z);
        logic signed [15:0] v;
        case (sel)
            Q_W:     v = w;
            Q_X:     v = x;
            Q_Y:     v = y;
            default: v = z;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] to_q13(input logic signed [27:0] zv,
                                                  input logic signed [16:0] lim);
        logic signed [27:0] t;
        logic signed [16:0] r;
        t = zv + 28'sd1024;
        r = t[27:11];
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    always_comb
    begin
        mul_a    = pick(cmd.mul_a_sel, qw_reg, qx_reg, qy_reg, qz_reg);
        mul_b    = pick(cmd.mul_b_sel, qw_reg, qx_reg, qy_reg, qz_reg);
        prod     = mul_a * mul_b;
        prod_ext = {prod[31], prod};
        acc_cur  = (cmd.acc_dst == ACC_A) ? acc_a_reg : acc_b_reg;
        case (cmd.acc_mode)
            ACC_ADD: acc_next = acc_cur + prod_ext;
            ACC_SUB: acc_next = acc_cur - prod_ext;
            default: acc_next = prod_ext;
        endcase
    end

    always_comb
    begin
        s_dbl = {acc_a_reg, 1'b0};
        if (s_dbl > 34'sd268435456)
        begin
            s_next = 30'sd268435456;
        end
        else if (s_dbl < -34'sd268435456)
        begin
            s_next = -30'sd268435456;
        end
        else
        begin
            s_next = s_dbl[29:0];
        end
        sq_full = s_reg * s_reg;
        trial   = r_reg + {1'b0, bit_reg};
    end

    always_comb
    begin
        if (cmd.atan_src == SRC_PITCH)
        begin
            yi = {{6{s_reg[29]}}, s_reg};
            xi = {7'd0, r_reg[28:0]};
        end
        else
        begin
            yi = {{2{acc_a_reg[32]}}, acc_a_reg, 1'b0};
            xi = ONE_Q28 - {{2{acc_b_reg[32]}}, acc_b_reg, 1'b0};
        end
        xs       = x_reg >>> it_reg;
        ys       = y_reg >>> it_reg;
        atan_ext = {4'd0, atan_q24(5'(it_reg))};
        z_round  = zero_reg ? 28'sd0 : z_reg;
    end

    always_comb
    begin
        angle     = to_q13(z_round, cmd.pitch_store ? LIM_HALF : LIM_FULL);
        thr       = LIM_HALF - $signed({3'd0, margin_reg});
        pitch_ext = {{2{pitch_reg[14]}}, pitch_reg};
    end

    assign status.root_done = (bit_reg == 57'd1);
    assign status.atan_done = (it_reg == IW'(CORDIC_STEPS - 1));
    assign status.pole_ok   = (pitch_ext < thr) && (pitch_ext > -thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg    <= MARGIN_RESET;
            last_roll_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                margin_reg <= cfg_data;
            end
            if (cmd.roll_store)
            begin
                last_roll_reg <= angle[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            qw_reg <= quat_w;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
        end
        if (cmd.acc_en && cmd.acc_dst == ACC_A)
        begin
            acc_a_reg <= acc_next;
        end
        if (cmd.acc_en && cmd.acc_dst == ACC_B)
        begin
            acc_b_reg <= acc_next;
        end
        if (cmd.s_load)
        begin
            s_reg <= s_next;
        end
        if (cmd.sq_load)
        begin
            sq_reg <= sq_full[56:0];
        end
        if (cmd.root_init)
        begin
            n_reg   <= ONE_Q56 - sq_reg;
            r_reg   <= '0;
            bit_reg <= ONE_Q56;
        end
        else if (cmd.root_step)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_reg <= n_reg - trial[56:0];
                r_reg <= (r_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.atan_init)
        begin
            it_reg   <= '0;
            zero_reg <= (xi == '0) && (yi == '0);
            if (xi < 0)
            begin
                if (yi >= 0)
                begin
                    x_reg <= yi;
                    y_reg <= -xi;
                    z_reg <= HALF_PI_Q24;
                end
                else
                begin
                    x_reg <= -yi;
                    y_reg <= xi;
                    z_reg <= -HALF_PI_Q24;
                end
            end
            else
            begin
                x_reg <= xi;
                y_reg <= yi;
                z_reg <= '0;
            end
        end
        else if (cmd.atan_step)
        begin
            it_reg <= it_reg + 1'b1;
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_ext;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_ext;
            end
        end
        if (cmd.pitch_store)
        begin
            pitch_reg <= angle[14:0];
        end
        if (cmd.yaw_store)
        begin
            yaw_reg <= angle[15:0];
        end
        if (cmd.roll_store)
        begin
            roll_reg <= angle[15:0];
            held_reg <= 1'b0;
        end
        else if (cmd.roll_hold)
        begin
            roll_reg <= last_roll_reg;
            held_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            roll_out_reg  <= roll_reg;
            pitch_out_reg <= pitch_reg;
            yaw_out_reg   <= yaw_reg;
            held_out_reg  <= held_reg;
        end
    end

    assign roll      = roll_out_reg;
    assign pitch     = pitch_out_reg;
    assign yaw       = yaw_out_reg;
    assign roll_held = held_out_reg;

endmodule

// ===== sv/qte_ctrl.sv =====
`include "assert_macros.svh"

module qte_ctrl
    import qte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  qte_status_t status,
    output qte_cmd_t    cmd
);

    typedef enum logic [25:0] {
        ST_IDLE        = 26'h0000001,
        ST_P_MUL0      = 26'h0000002,
        ST_P_MUL1      = 26'h0000004,
        ST_P_CLAMP     = 26'h0000008,
        ST_P_SQUARE    = 26'h0000010,
        ST_P_ROOT_INIT = 26'h0000020,
        ST_P_ROOT      = 26'h0000040,
        ST_P_ATAN_INIT = 26'h0000080,
        ST_P_ATAN      = 26'h0000100,
        ST_P_STORE     = 26'h0000200,
        ST_Y_MUL0      = 26'h0000400,
        ST_Y_MUL1      = 26'h0000800,
        ST_Y_MUL2      = 26'h0001000,
        ST_Y_MUL3      = 26'h0002000,
        ST_Y_ATAN_INIT = 26'h0004000,
        ST_Y_ATAN      = 26'h0008000,
        ST_Y_STORE     = 26'h0010000,
        ST_R_MUL0      = 26'h0020000,
        ST_R_MUL1      = 26'h0040000,
        ST_R_MUL2      = 26'h0080000,
        ST_R_MUL3      = 26'h0100000,
        ST_R_ATAN_INIT = 26'h0200000,
        ST_R_ATAN      = 26'h0400000,
        ST_R_STORE     = 26'h0800000,
        ST_R_HOLD      = 26'h1000000,
        ST_FINISH      = 26'h2000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_a_sel = Q_W;
        cmd.mul_b_sel = Q_W;
        cmd.acc_dst   = ACC_A;
        cmd.acc_mode  = ACC_LOAD;
        cmd.atan_src  = SRC_EULER;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_P_MUL0;
                end
            end
            ST_P_MUL0:
            begin
                cmd.acc_en    = 1'b1;
                cmd.mul_a_sel = Q_W;
                cmd.mul_b_sel = Q_Y;
                state_next    = ST_P_MUL1;
            end
            ST_P_MUL1:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_mode  = ACC_SUB;
                cmd.mul_a_sel = Q_X;
                cmd.mul_b_sel = Q_Z;
                state_next    = ST_P_CLAMP;
            end
            ST_P_CLAMP:
            begin
                cmd.s_load = 1'b1;
                state_next = ST_P_SQUARE;
            end
            ST_P_SQUARE:
            begin
                cmd.sq_load = 1'b1;
                state_next  = ST_P_ROOT_INIT;
            end
            ST_P_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = ST_P_ROOT;
            end
            ST_P_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                begin
                    state_next = ST_P_ATAN_INIT;
                end
            end
            ST_P_ATAN_INIT:
            begin
                cmd.atan_init = 1'b1;
                cmd.atan_src  = SRC_PITCH;
                state_next    = ST_P_ATAN;
            end
            ST_P_ATAN:
            begin
                cmd.atan_step = 1'b1;
                if (status.atan_done)
                begin
                    state_next = ST_P_STORE;
                end
            end
            ST_P_STORE:
            begin
                cmd.pitch_store = 1'b1;
                state_next      = ST_Y_MUL0;
            end
            ST_Y_MUL0:
            begin
                cmd.acc_en    = 1'b1;
                cmd.mul_a_sel = Q_X;
                cmd.mul_b_sel = Q_Y;
                state_next    = ST_Y_MUL1;
            end
            ST_Y_MUL1:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_mode  = ACC_ADD;
                cmd.mul_a_sel = Q_W;
                cmd.mul_b_sel = Q_Z;
                state_next    = ST_Y_MUL2;
            end
            ST_Y_MUL2:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_dst   = ACC_B;
                cmd.mul_a_sel = Q_Y;
                cmd.mul_b_sel = Q_Y;
                state_next    = ST_Y_MUL3;
            end
            ST_Y_MUL3:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_dst   = ACC_B;
                cmd.acc_mode  = ACC_ADD;
                cmd.mul_a_sel = Q_Z;
                cmd.mul_b_sel = Q_Z;
                state_next    = ST_Y_ATAN_INIT;
            end
            ST_Y_ATAN_INIT:
            begin
                cmd.atan_init = 1'b1;
                state_next    = ST_Y_ATAN;
            end
            ST_Y_ATAN:
            begin
                cmd.atan_step = 1'b1;
                if (status.atan_done)
                begin
                    state_next = ST_Y_STORE;
                end
            end
            ST_Y_STORE:
            begin
                cmd.yaw_store = 1'b1;
                state_next    = status.pole_ok ? ST_R_MUL0 : ST_R_HOLD;
            end
            ST_R_MUL0:
            begin
                cmd.acc_en    = 1'b1;
                cmd.mul_a_sel = Q_Y;
                cmd.mul_b_sel = Q_Z;
                state_next    = ST_R_MUL1;
            end
            ST_R_MUL1:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_mode  = ACC_ADD;
                cmd.mul_a_sel = Q_W;
                cmd.mul_b_sel = Q_X;
                state_next    = ST_R_MUL2;
            end
            ST_R_MUL2:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_dst   = ACC_B;
                cmd.mul_a_sel = Q_X;
                cmd.mul_b_sel = Q_X;
                state_next    = ST_R_MUL3;
            end
            ST_R_MUL3:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_dst   = ACC_B;
                cmd.acc_mode  = ACC_ADD;
                cmd.mul_a_sel = Q_Y;
                cmd.mul_b_sel = Q_Y;
                state_next    = ST_R_ATAN_INIT;
            end
            ST_R_ATAN_INIT:
            begin
                cmd.atan_init = 1'b1;
                state_next    = ST_R_ATAN;
            end
            ST_R_ATAN:
            begin
                cmd.atan_step = 1'b1;
                if (status.atan_done)
                begin
                    state_next = ST_R_STORE;
                end
            end
            ST_R_STORE:
            begin
                cmd.roll_store = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_R_HOLD:
            begin
                cmd.roll_hold = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall)
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_reg == ST_P_MUL0)
    `ASSERT_NEXT(a_pole_hold, clk, rst_n, state_reg == ST_Y_STORE && !status.pole_ok, state_reg == ST_R_HOLD)

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// Converts one attitude quaternion (w, x, y, z in signed Q2.14) per beat into roll, pitch
// and yaw in signed radians (roll and yaw Q3.13, pitch Q2.13), with a one-beat output
// register. Items are handled one at a time. When the pitch lies within the configured
// margin (margin_reg) of a pole, the previous roll is repeated with roll_held set. The
// datapath uses one shared 16 x 16 multiplier, a 29-step square root for the asin argument
// and a single CORDIC unit that evaluates the pitch, yaw and (unless held) roll arctangents
// in turn. The next item is taken once the current result has moved into the output
// register.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [13:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll,
    output logic signed [14:0] pitch,
    output logic signed [15:0] yaw,
    output logic               roll_held
);

    qte_cmd_t    cmd;
    qte_status_t status;

    qte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    qte_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .cmd       (cmd),
        .status    (status),
        .roll      (roll),
        .pitch     (pitch),
        .yaw       (yaw),
        .roll_held (roll_held)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import qte_pkg::*;

    localparam int STEPS = 16;
    localparam int LIMIT = 2000000;
    localparam int SETTLE = 3 * STEPS + 80;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               held;
    } euler_t;

    class euler_scoreboard;
        euler_t     pending_angles[$];
        longint     last_roll;
        longint     margin;
        int         errors;
        int         checked;
        int         held_seen;
        longint     atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                     262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                                     1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

        function void clear();
            pending_angles.delete();
            last_roll = 0;
            margin = MARGIN_RESET;
            errors = 0;
            checked = 0;
            held_seen = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint a;
            longint t;
            longint xs;
            longint ys;
            a = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    a = 26353589;
                end
                else
                begin
                    x = -y;
                    y = t;
                    a = -26353589;
                end
            end
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    a = a + atan_tab[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    a = a - atan_tab[i];
                end
            end
            return a;
        endfunction

        function longint round_q13(longint a, longint lim);
            longint r;
            r = (a + 1024) >>> 11;
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            return r;
        endfunction

        function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                                logic signed [15:0] qy, logic signed [15:0] qz);
            longint w;
            longint x;
            longint y;
            longint z;
            longint s;
            longint c;
            longint p;
            longint thr;
            euler_t e;
            w = qw;
            x = qx;
            y = qy;
            z = qz;
            s = 2 * (w * y - x * z);
            if (s > (64'sd1 <<< 28))
                s = 64'sd1 <<< 28;
            if (s < -(64'sd1 <<< 28))
                s = -(64'sd1 <<< 28);
            c = longint'(int_sqrt((64'd1 << 56) - longint'(s * s)));
            p = round_q13(vector_angle(s, c), 12868);
            e.pitch = p[14:0];
            e.yaw = 16'(round_q13(vector_angle(2 * (x * y + w * z),
                (64'sd1 <<< 28) - 2 * (y * y + z * z)), 25736));
            thr = 12868 - margin;
            if (p < thr && p > -thr)
            begin
                last_roll = round_q13(vector_angle(2 * (y * z + w * x),
                    (64'sd1 <<< 28) - 2 * (x * x + y * y)), 25736);
                e.held = 1'b0;
            end
            else
                e.held = 1'b1;
            e.roll = last_roll[15:0];
            pending_angles.push_back(e);
        endfunction

        function void check_angles(euler_t got);
            euler_t e;
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d held=%0b",
                         $time, got.roll, got.pitch, got.yaw, got.held);
                errors++;
                return;
            end
            e = pending_angles.pop_front();
            checked++;
            if (e.held)
                held_seen++;
            if (got.roll !== e.roll)
            begin
                $display("%0t: roll expected %0d actual %0d", $time, e.roll, got.roll);
                errors++;
            end
            if (got.pitch !== e.pitch)
            begin
                $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== e.yaw)
            begin
                $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, got.yaw);
                errors++;
            end
            if (got.held !== e.held)
            begin
                $display("%0t: roll_held expected %0b actual %0b", $time, e.held, got.held);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [13:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               roll_held;

    euler_scoreboard sb;
    bit              idle_on;
    bit              long_hold;
    int              cycles = 0;
    int              sent;

    quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll(roll), .pitch(pitch), .yaw(yaw), .roll_held(roll_held)
    );

    initial
    begin
        clk = 1'b0;
        sb = new();
        sb.clear();
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("quaternion_to_euler_angles verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        euler_t got;
        got.roll = roll;
        got.pitch = pitch;
        got.yaw = yaw;
        got.held = roll_held;
        if (rst_n && out_valid && !out_stall)
            sb.check_angles(got);
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (800) @(negedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_quat(input int w, input int x, input int y, input int z);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= 16'(w);
        quat_x <= 16'(x);
        quat_y <= 16'(y);
        quat_z <= 16'(z);
        do
            @(posedge clk);
        while (in_stall);
        sb.note_quat(quat_w, quat_x, quat_y, quat_z);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_angles.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_margin(input int v);
        cfg_write <= 1'b1;
        cfg_data <= 14'(v);
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.margin = v;
    endtask

    function automatic int rnd(int lo, int hi);
        return int'($urandom_range(hi - lo, 0)) + lo;
    endfunction

    task automatic send_random();
        int a;
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            send_quat(rnd(-16384, 16384), rnd(-16384, 16384),
                      rnd(-16384, 16384), rnd(-16384, 16384));
        else if (k < 7)
            send_quat(rnd(-8192, 8192), rnd(-8192, 8192), rnd(-8192, 8192), rnd(-8192, 8192));
        else
        begin
            a = rnd(10000, 12500);
            if (k == 9)
                send_quat(a, rnd(-600, 600), -a + rnd(-300, 300), rnd(-600, 600));
            else
                send_quat(a, rnd(-600, 600), a + rnd(-300, 300), rnd(-600, 600));
        end
    endtask

    initial
    begin
        int margins[5];
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        idle_on = 1'b1;
        long_hold = 1'b0;
        sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(0, 0, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 2000, 11585, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, -16384, 0, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(-16384, 16384, -16384, 16384);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(1, -1, 1, -1);
        send_quat(11585, 11585, 0, 0);
        send_quat(0, 11585, 11585, 0);
        send_quat(12000, 0, 11000, 0);
        drain();

        margins = '{0, 12868, 16383, 410, 800};
        margins[3] = rnd(1, 12867);
        for (int ph = 0; ph < 5; ph++)
        begin
            write_margin(margins[ph]);
            if (ph == 4)
                idle_on = 1'b0;
            for (int i = 0; i < 190; i++)
            begin
                if (ph == 1 && i == 20)
                    long_hold = 1'b1;
                if (ph == 2 && i == 90)
                    drain();
                send_random();
            end
            drain();
        end

        $display("Sent %0d quaternions over five pole margins, checked %0d results.",
                 sent, sb.checked);
        $display("Held roll %0d times; one long output stall and random idling.",
                 sb.held_seen);
        if (sb.errors == 0 && sb.pending_angles.size() == 0)
            $display("quaternion_to_euler_angles verification clean");
        else
            $display("quaternion_to_euler_angles verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/qte_pkg.sv
sv/qte_datapath.sv
sv/qte_ctrl.sv
sv/quaternion_to_euler_angles.sv
tb/tb.sv
